FILE: src/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Types and constants shared by the vertex transform and its divider.
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 48;	// product after the low 16 bits are dropped
	localparam int SUM_W     = 50;	// four products added exactly
	localparam int DIV_BITS  = 48;	// dividend magnitude bits, one per divider stage

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 50'sd2147483647;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -50'sd2147483648;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000,
		64'h0,                   64'h0001_0000_0000_0000
	};

	// Everything that rides alongside the divider.
	typedef struct packed {
		logic                     point;
		logic                     w_zero;
		logic                     sat;
		logic [2:0]               neg;
		logic [3:0][DATA_W-1:0]   res;
	} side_t;

endpackage

FILE: src/vtpd_if.sv
// ----------------------------------------------------------------------------
// vtpd_in_if / vtpd_out_if
// Valid/ready channels for vertices into and results out of the transform.
// ----------------------------------------------------------------------------
interface vtpd_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] vin_x;
	logic signed [31:0] vin_y;
	logic signed [31:0] vin_z;
	logic signed [31:0] vin_w;

	modport source (output valid, req_type, vin_x, vin_y, vin_z, vin_w, input ready);
	modport sink   (input valid, req_type, vin_x, vin_y, vin_z, vin_w, output ready);
endinterface

interface vtpd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vout_x;
	logic signed [31:0] vout_y;
	logic signed [31:0] vout_z;
	logic signed [31:0] vout_w;
	logic               saturated;
	logic               w_zero;

	modport source (output valid, vout_x, vout_y, vout_z, vout_w, saturated, w_zero,
		input ready);
	modport sink   (input valid, vout_x, vout_y, vout_z, vout_w, saturated, w_zero,
		output ready);
endinterface

FILE: src/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// Q16.16 4x4 matrix times vertex, with optional perspective divide by w.
// ----------------------------------------------------------------------------
// The matrix sits in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_data; two Q16.16 entries per register, even column in
// the low half. Reset loads the identity matrix and empties the pipeline.
// Write the matrix only while no vertex is in flight.
//
// Vertices arrive on vtx_in and results leave on vtx_out, both valid/ready.
// A transfer on vtx_in enters stage 1 (sixteen multipliers), stage 2 adds
// and clamps each row, stage 3 takes magnitudes for the divide, then 48
// divider stages produce one quotient bit each, and a final stage restores
// signs, clamps and registers the result. That is 52 register stages from
// the input transfer to the result register; throughput is one vertex per
// cycle while the receiver keeps taking results.
// The 48-stage bit-per-stage divider sets the latency.
//
// The whole pipeline moves together: it advances whenever the output
// register is empty or its contents are taken in the same cycle. When the
// receiver holds ready low with a result waiting, every stage holds and
// vtx_in.ready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide
	import vtpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [REG_W-1:0]   cfg_data,
	vtpd_in_if.sink            vtx_in,
	vtpd_out_if.source         vtx_out
);

	logic [REG_W-1:0] mat_q [NUM_REGS];
	logic             adv;

	// Matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) mat_q[i] <= REG_RESET[i];
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// The output register is the last stage; everything shifts on adv.
	assign adv          = !vtx_out.valid || vtx_out.ready;
	assign vtx_in.ready = adv;

	// ---------------- Stage 1: sixteen products, low 16 bits dropped.
	logic signed [DATA_W-1:0] vin [4];
	logic signed [63:0]       prod [4][4];
	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic                     vld_s1, point_s1;

	always_comb begin
		vin[0] = vtx_in.vin_x;
		vin[1] = vtx_in.vin_y;
		vin[2] = vtx_in.vin_z;
		vin[3] = vtx_in.req_type ? $signed(ONE_Q16) : vtx_in.vin_w;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod[r][c] = $signed(mat_q[r*2 + c/2][(c%2)*DATA_W +: DATA_W]) * vin[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_s1 <= vtx_in.req_type;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					prod_s1[r][c] <= prod[r][c][63:16];
		end
	end

	// ---------------- Stage 2: row sums, clamped to 32 bits.
	logic signed [SUM_W-1:0]  sum [4];
	logic [3:0]               row_sat;
	logic signed [DATA_W-1:0] row_clamp [4];
	logic signed [DATA_W-1:0] res_s2 [4];
	logic                     vld_s2, point_s2, sat_s2;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
				+ SUM_W'(prod_s1[r][2]) + SUM_W'(prod_s1[r][3]);
			row_sat[r] = 1'b1;
			if (sum[r] > SUM_MAX)      row_clamp[r] = 32'sh7fff_ffff;
			else if (sum[r] < SUM_MIN) row_clamp[r] = 32'sh8000_0000;
			else begin
				row_clamp[r] = sum[r][DATA_W-1:0];
				row_sat[r]   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_s2 <= point_s1;
			sat_s2   <= |row_sat;
			for (int r = 0; r < 4; r++) res_s2[r] <= row_clamp[r];
		end
	end

	// ---------------- Stage 3: magnitudes and signs for the divide.
	logic [DATA_W-1:0]   w_mag;
	logic [DATA_W-1:0]   num_mag [3];
	logic                w_is_zero;
	logic [DIV_BITS-1:0] dvd_s3 [3];
	logic [DATA_W-1:0]   dvs_s3;
	side_t               side_s3;
	logic                vld_s3;

	always_comb begin
		w_is_zero = res_s2[3] == '0;
		w_mag     = res_s2[3][DATA_W-1] ? DATA_W'(-res_s2[3]) : DATA_W'(res_s2[3]);
		for (int r = 0; r < 3; r++)
			num_mag[r] = res_s2[r][DATA_W-1] ? DATA_W'(-res_s2[r]) : DATA_W'(res_s2[r]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// A zero divisor is replaced by one; its quotient is discarded.
			dvs_s3          <= w_is_zero ? DATA_W'(1) : w_mag;
			side_s3.point   <= point_s2;
			side_s3.w_zero  <= point_s2 && w_is_zero;
			side_s3.sat     <= sat_s2;
			for (int r = 0; r < 3; r++) begin
				dvd_s3[r]      <= {num_mag[r], 16'h0};
				side_s3.neg[r] <= res_s2[r][DATA_W-1] ^ res_s2[3][DATA_W-1];
			end
			for (int r = 0; r < 4; r++) side_s3.res[r] <= res_s2[r];
		end
	end

	// ---------------- Divider stages, with side information delayed alongside.
	logic [DIV_BITS-1:0] quo [3];
	side_t               side_d [DIV_BITS];
	logic [DIV_BITS-1:0] vld_d;

	for (genvar l = 0; l < 3; l++) begin : g_lane
		vtpd_div u_div (
			.clk      (clk),
			.adv      (adv),
			.dividend (dvd_s3[l]),
			.divisor  (dvs_s3),
			.quotient (quo[l])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s3;
			for (int k = 1; k < DIV_BITS; k++) side_d[k] <= side_d[k-1];
		end
	end

	// ---------------- Output stage: sign, clamp, zero-w handling.
	localparam logic [DIV_BITS-1:0] POS_LIM = DIV_BITS'(32'h7fff_ffff);
	localparam logic [DIV_BITS-1:0] NEG_LIM = DIV_BITS'(32'h8000_0000);

	side_t                    side_f;
	logic signed [DATA_W-1:0] q_val [3];
	logic [2:0]               q_sat;
	logic signed [DATA_W-1:0] out_xyz [3];
	logic                     out_sat;
	logic signed [DATA_W-1:0] vx_q, vy_q, vz_q, vw_q;
	logic                     sat_q, wz_q, vld_q;

	assign side_f = side_d[DIV_BITS-1];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			q_sat[r] = 1'b0;
			if (side_f.neg[r]) begin
				if (quo[r] > NEG_LIM) begin
					q_val[r] = 32'sh8000_0000;
					q_sat[r] = 1'b1;
				end else begin
					q_val[r] = -$signed(quo[r][DATA_W-1:0]);
				end
			end else begin
				if (quo[r] > POS_LIM) begin
					q_val[r] = 32'sh7fff_ffff;
					q_sat[r] = 1'b1;
				end else begin
					q_val[r] = $signed(quo[r][DATA_W-1:0]);
				end
			end
			if (!side_f.point)      out_xyz[r] = side_f.res[r];
			else if (side_f.w_zero) out_xyz[r] = '0;
			else                    out_xyz[r] = q_val[r];
		end
		out_sat = side_f.sat || (side_f.point && !side_f.w_zero && (|q_sat));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_q  <= out_xyz[0];
			vy_q  <= out_xyz[1];
			vz_q  <= out_xyz[2];
			vw_q  <= side_f.res[3];
			sat_q <= out_sat;
			wz_q  <= side_f.w_zero;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_d  <= '0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vtx_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_d  <= {vld_d[DIV_BITS-2:0], vld_s3};
			vld_q  <= vld_d[DIV_BITS-1];
		end
	end

	assign vtx_out.valid     = vld_q;
	assign vtx_out.vout_x    = vx_q;
	assign vtx_out.vout_y    = vy_q;
	assign vtx_out.vout_z    = vz_q;
	assign vtx_out.vout_w    = vw_q;
	assign vtx_out.saturated = sat_q;
	assign vtx_out.w_zero    = wz_q;

	// A zero w result carries zeros in every component.
	a_wzero_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && wz_q |-> vx_q == '0 && vy_q == '0 && vz_q == '0 && vw_q == '0)
		else $error("w_zero result with nonzero components");

	// A stalled pipeline holds its stage 3 and divider valid bits.
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s3) && $stable(vld_d))
		else $error("pipeline moved during stall");

	// An item in stage 3 reaches the first divider stage on the next advance.
	a_s3_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s3 |=> vld_d[0])
		else $error("item lost entering divider");

	// A zero w flag only comes with a point-mode item.
	a_wzero_point: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && side_s3.w_zero |-> side_s3.point)
		else $error("w_zero set outside point mode");

endmodule

FILE: src/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtpd_div
	import vtpd_pkg::*;
(
	input  logic                clk,
	input  logic                adv,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DATA_W-1:0]   divisor,
	output logic [DIV_BITS-1:0] quotient
);

	// Index 0 is the input; index k+1 is the register after stage k.
	// The last stage only produces quotient bits, so the partial remainder
	// and divisor stop one stage earlier.
	logic [DATA_W-1:0]   rem [DIV_BITS];
	logic [DIV_BITS-1:0] dq  [DIV_BITS+1];
	logic [DATA_W-1:0]   dv  [DIV_BITS];

	assign rem[0] = '0;
	assign dq[0]  = dividend;
	assign dv[0]  = divisor;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
		logic [DATA_W:0] trial;
		logic [DATA_W:0] diff;
		logic            ge;

		assign trial = {rem[k], dq[k][DIV_BITS-1]};
		assign diff  = trial - {1'b0, dv[k]};
		assign ge    = trial >= {1'b0, dv[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				dq[k+1] <= {dq[k][DIV_BITS-2:0], ge};
			end
		end

		if (k < DIV_BITS-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem[k+1] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
					dv[k+1]  <= dv[k];
				end
			end
		end
	end

	assign quotient = dq[DIV_BITS];

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 vertex transform with perspective divide.
// The bench streams vertices through the valid/ready channels under several
// matrices and stall patterns. Each result is compared field by field with
// the value predicted for the matrix that was loaded when the vertex went in.
// ----------------------------------------------------------------------------
module tb
	import vtpd_pkg::*;
;

	// Cycles to let pass once the pipeline is drained. This is above the
	// input-to-output latency of the pipeline.
	localparam int DRAIN_CYCLES = 64;
	// Watchdog limit on cycles without any transfer. The drain pause and
	// long output stalls fit well inside this limit.
	localparam int STALL_LIMIT  = 4000;

	localparam logic REQ_VECTOR = 1'b0;
	localparam logic REQ_POINT  = 1'b1;

	typedef struct {
		logic               req_type;
		logic signed [31:0] x, y, z, w;
	} vertex_t;

	typedef struct {
		logic signed [31:0] x, y, z, w;
		logic               saturated;
		logic               w_zero;
	} xform_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	vtpd_in_if  in_if();
	vtpd_out_if out_if();

	vertex_transform_perspective_divide dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vtx_in(in_if), .vtx_out(out_if)
	);

	always #5 clk = ~clk;

	// The bench's own copy of the matrix registers, loaded on every write.
	logic [REG_W-1:0] matrix [NUM_REGS];
	vertex_t vertex_q [$];
	xform_t  xform_q [$];
	int      errors = 0;
	int      src_idle_pct = 0;
	int      snk_idle_pct = 0;
	logic    in_taken = 1'b0;
	int      quiet_cycles = 0;

	initial begin
		in_if.valid = 1'b0;
		in_if.req_type = 1'b0;
		in_if.vin_x = '0;
		in_if.vin_y = '0;
		in_if.vin_z = '0;
		in_if.vin_w = '0;
		out_if.ready = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) matrix[i] = REG_RESET[i];
	end

	// Saturate a wide value to the signed 32-bit range and note any clamp.
	function automatic longint clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Matrix times vertex, then the divide by w when the item is a point.
	function automatic xform_t transform_vertex(vertex_t v);
		longint vec [4];
		longint sums [4];
		longint coef, prod, acc;
		logic [REG_W-1:0] reg_val;
		bit sat;
		xform_t r;
		sat = 1'b0;
		vec[0] = v.x;
		vec[1] = v.y;
		vec[2] = v.z;
		vec[3] = (v.req_type == REQ_POINT) ? longint'(signed'(ONE_Q16)) : longint'(v.w);
		for (int row = 0; row < 4; row++) begin
			acc = 0;
			for (int col = 0; col < 4; col++) begin
				reg_val = matrix[row*2 + col/2];
				coef = (col % 2) ? longint'(signed'(reg_val[63:32]))
					: longint'(signed'(reg_val[31:0]));
				prod = coef * vec[col];
				// Dropping the fraction is an arithmetic shift: toward minus infinity.
				acc += prod >>> 16;
			end
			sums[row] = clamp32(acc, sat);
		end
		r.w_zero = 1'b0;
		if (v.req_type == REQ_POINT) begin
			if (sums[3] == 0) begin
				r.w_zero = 1'b1;
				for (int row = 0; row < 3; row++) sums[row] = 0;
			end else begin
				// Division of signed integers truncates toward zero.
				for (int row = 0; row < 3; row++)
					sums[row] = clamp32((sums[row] * 65536) / sums[3], sat);
			end
		end
		r.x = sums[0][31:0];
		r.y = sums[1][31:0];
		r.z = sums[2][31:0];
		r.w = sums[3][31:0];
		r.saturated = sat;
		return r;
	endfunction

	// Input driver: a new vertex goes out once the previous one was taken.
	always @(negedge clk) begin : drive_vertices
		vertex_t v;
		if (arst_n) begin
			if (!in_if.valid || in_taken) begin
				if (vertex_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					v = vertex_q.pop_front();
					in_if.req_type <= v.req_type;
					in_if.vin_x <= v.x;
					in_if.vin_y <= v.y;
					in_if.vin_z <= v.z;
					in_if.vin_w <= v.w;
					in_if.valid <= 1'b1;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
			out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Monitor: predicts on every input transfer, checks every output transfer.
	always @(posedge clk) begin : watch_channels
		vertex_t v;
		xform_t  e;
		in_taken <= in_if.valid && in_if.ready;
		if (arst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
			v.req_type = in_if.req_type;
			v.x = in_if.vin_x;
			v.y = in_if.vin_y;
			v.z = in_if.vin_z;
			v.w = in_if.vin_w;
			xform_q.push_back(transform_vertex(v));
		end
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (xform_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: %h %h %h %h", $time,
					out_if.vout_x, out_if.vout_y, out_if.vout_z, out_if.vout_w);
			end else begin
				e = xform_q.pop_front();
				check_field("vout_x", e.x, out_if.vout_x);
				check_field("vout_y", e.y, out_if.vout_y);
				check_field("vout_z", e.z, out_if.vout_z);
				check_field("vout_w", e.w, out_if.vout_w);
				check_field("saturated", {31'b0, e.saturated}, {31'b0, out_if.saturated});
				check_field("w_zero", {31'b0, e.w_zero}, {31'b0, out_if.w_zero});
			end
		end
		// Watchdog: any transfer on either side restarts the count.
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Random Q16.16 value, biased toward extremes, small magnitudes and
	// mid-range numbers so that both clamps and exact results show up.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'(int'($urandom_range(8 << 16)) - (4 << 16));
			2: case ($urandom_range(4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0;
				3: return ONE_Q16;
				default: return 32'hFFFF_0000;
			endcase
			default: return 32'(int'($urandom_range(1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic vertex_t make_vertex(logic req, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] w);
		vertex_t v;
		v.req_type = req;
		v.x = x;
		v.y = y;
		v.z = z;
		v.w = w;
		return v;
	endfunction

	// Register writes happen at falling edges, only while the pipeline is empty.
	task automatic load_matrix(logic [REG_W-1:0] m [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= m[i];
			matrix[i] = m[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Build a matrix of the given kind. For kinds 4 and up, row 3 is sometimes
	// zeroed or made to follow z, so point mode meets a zero w.
	task automatic build_matrix(int kind, output logic [REG_W-1:0] m [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			case (kind)
				0: m[i] = REG_RESET[i];
				1: m[i] = {2{32'h7FFF_FFFF}};
				2: m[i] = {2{32'h8000_0000}};
				3: m[i] = {$urandom, $urandom};
				default: m[i] = {pick_value(), pick_value()};
			endcase
		end
		if (kind >= 4) begin
			case ($urandom_range(3))
				0: begin
					m[6] = '0;
					m[7] = '0;
				end
				1: begin
					// Classic perspective row: w follows z.
					m[6] = '0;
					m[7] = {32'h0, ONE_Q16};
				end
				default: ;
			endcase
		end
	endtask

	task automatic wait_drained();
		while (vertex_q.size() > 0 || in_if.valid || xform_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : run
		logic [REG_W-1:0] m [NUM_REGS];
		logic [31:0] edge_vals [5];
		edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, ONE_Q16};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset identity matrix: each extreme value
		// in every field, in both request types.
		for (int i = 0; i < 5; i++) begin
			vertex_q.push_back(make_vertex(REQ_VECTOR, edge_vals[i], edge_vals[(i+1)%5],
				edge_vals[(i+2)%5], edge_vals[(i+3)%5]));
			vertex_q.push_back(make_vertex(REQ_POINT, edge_vals[(i+4)%5], edge_vals[i],
				edge_vals[(i+1)%5], edge_vals[(i+2)%5]));
		end
		wait_drained();

		// Extreme matrices: every row saturates; with a zero row 3 every
		// point meets a zero w.
		for (int kind = 1; kind <= 2; kind++) begin
			build_matrix(kind, m);
			load_matrix(m);
			vertex_q.push_back(make_vertex(REQ_VECTOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'h7FFF_FFFF));
			vertex_q.push_back(make_vertex(REQ_POINT, 32'h8000_0000, 32'h0,
				ONE_Q16, 32'h0));
			vertex_q.push_back(make_vertex(REQ_POINT, ONE_Q16, 32'h0, 32'h0, 32'h0));
			wait_drained();
		end
		build_matrix(0, m);
		m[6] = '0;
		m[7] = '0;
		load_matrix(m);
		vertex_q.push_back(make_vertex(REQ_POINT, 32'h0003_0000, 32'hFFFE_0000,
			32'h7FFF_FFFF, 32'h1234_5678));
		vertex_q.push_back(make_vertex(REQ_VECTOR, 32'h0003_0000, 32'hFFFE_0000,
			32'h7FFF_FFFF, 32'h0));
		wait_drained();

		// Random part: nine phases, three per stall pattern, each with a
		// fresh matrix. Most vertices are points, which exercise the divide.
		for (int phase = 0; phase < 9; phase++) begin
			case (phase / 3)
				0: begin
					src_idle_pct = 6;
					snk_idle_pct = 64;
				end
				1: begin
					src_idle_pct = 64;
					snk_idle_pct = 6;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			build_matrix((phase == 4) ? 3 : 4 + phase, m);
			load_matrix(m);
			for (int n = 0; n < 122; n++)
				vertex_q.push_back(make_vertex(($urandom_range(9) < 6) ? REQ_POINT : REQ_VECTOR,
					pick_value(), pick_value(), pick_value(), pick_value()));
			wait_drained();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
